/* hdl/rc4v_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rc4v_pkg - shared types, constants and microcode for the RC4-style cipher
// Holds the control word layout, step codes and the sequencer program.
// ----------------------------------------------------------------------------
package rc4v_pkg;

    localparam int KEY_BITS_DEF = 64;
    localparam int BYTE_W       = 8;
    localparam int PERM_DEPTH   = 256;
    localparam int STEP_W       = 4;

    // sequencer steps
    localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] ST_FILL   = 4'd1;
    localparam logic [STEP_W-1:0] ST_KPRIME = 4'd2;
    localparam logic [STEP_W-1:0] ST_K1     = 4'd3;
    localparam logic [STEP_W-1:0] ST_K2     = 4'd4;
    localparam logic [STEP_W-1:0] ST_K3     = 4'd5;
    localparam logic [STEP_W-1:0] ST_KEND   = 4'd6;
    localparam logic [STEP_W-1:0] ST_B1     = 4'd7;
    localparam logic [STEP_W-1:0] ST_B2     = 4'd8;
    localparam logic [STEP_W-1:0] ST_B3     = 4'd9;

    typedef enum logic [1:0] {RA_I, RA_I1, RA_JSUM, RA_K} rd_src_t;
    typedef enum logic [1:0] {WA_N, WA_I, WA_J} wa_src_t;
    typedef enum logic [1:0] {WD_N, WD_RD, WD_SI} wd_src_t;
    typedef enum logic [1:0] {I_KEEP, I_CLR, I_INC, I_INC_ACC} i_op_t;
    typedef enum logic [2:0] {BR_NEXT, BR_GOTO, BR_IDLE, BR_FILL, BR_KEY, BR_EMIT} br_t;

    typedef struct packed {
        rd_src_t           rd_src;
        logic              rd_en;
        logic              rd_on_acc;
        logic              we;
        wa_src_t           wa_src;
        wd_src_t           wd_src;
        i_op_t             i_op;
        logic              j_clr;
        logic              j_load;
        logic              use_kbit;
        logic              n_inc;
        logic              si_load;
        logic              k_load;
        logic              pend_clr;
        logic              emit;
        logic              acc_ok;
        br_t               br;
        logic [STEP_W-1:0] target;
    } cw_t;

    typedef struct packed {
        logic pending;
        logic accept;
        logic n_last;
        logic i_last;
        logic out_free;
        logic restart;
    } cond_t;

    function automatic cw_t rom_word(input logic [STEP_W-1:0] step);
        cw_t w;
        w = '{rd_src: RA_I, rd_en: 1'b0, rd_on_acc: 1'b0, we: 1'b0, wa_src: WA_N,
              wd_src: WD_N, i_op: I_KEEP, j_clr: 1'b0, j_load: 1'b0, use_kbit: 1'b0,
              n_inc: 1'b0, si_load: 1'b0, k_load: 1'b0, pend_clr: 1'b0, emit: 1'b0,
              acc_ok: 1'b0, br: BR_NEXT, target: ST_IDLE};
        unique case (step)
            ST_IDLE:
            begin
                w.rd_src    = RA_I1;
                w.rd_on_acc = 1'b1;
                w.i_op      = I_INC_ACC;
                w.acc_ok    = 1'b1;
                w.br        = BR_IDLE;
                w.target    = ST_FILL;
            end
            ST_FILL:
            begin
                w.we     = 1'b1;
                w.wa_src = WA_N;
                w.wd_src = WD_N;
                w.n_inc  = 1'b1;
                w.i_op   = I_CLR;
                w.j_clr  = 1'b1;
                w.br     = BR_FILL;
            end
            ST_KPRIME:
            begin
                w.rd_src = RA_I;
                w.rd_en  = 1'b1;
            end
            ST_K1:
            begin
                w.rd_src   = RA_JSUM;
                w.rd_en    = 1'b1;
                w.use_kbit = 1'b1;
                w.j_load   = 1'b1;
                w.si_load  = 1'b1;
            end
            ST_K2:
            begin
                w.we     = 1'b1;
                w.wa_src = WA_I;
                w.wd_src = WD_RD;
            end
            ST_K3:
            begin
                w.we     = 1'b1;
                w.wa_src = WA_J;
                w.wd_src = WD_SI;
                w.rd_src = RA_I1;
                w.rd_en  = 1'b1;
                w.i_op   = I_INC;
                w.br     = BR_KEY;
                w.target = ST_K1;
            end
            ST_KEND:
            begin
                w.pend_clr = 1'b1;
                w.br       = BR_GOTO;
                w.target   = ST_IDLE;
            end
            ST_B1:
            begin
                w.rd_src  = RA_JSUM;
                w.rd_en   = 1'b1;
                w.j_load  = 1'b1;
                w.si_load = 1'b1;
            end
            ST_B2:
            begin
                w.we     = 1'b1;
                w.wa_src = WA_I;
                w.wd_src = WD_RD;
                w.rd_src = RA_K;
                w.rd_en  = 1'b1;
                w.k_load = 1'b1;
            end
            ST_B3:
            begin
                w.we        = 1'b1;
                w.wa_src    = WA_J;
                w.wd_src    = WD_SI;
                w.rd_src    = RA_I1;
                w.rd_on_acc = 1'b1;
                w.i_op      = I_INC_ACC;
                w.emit      = 1'b1;
                w.acc_ok    = 1'b1;
                w.br        = BR_EMIT;
                w.target    = ST_IDLE;
            end
            default:
            begin
                w.br     = BR_GOTO;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* hdl/rc4v_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rc4v_seq - microcode sequencer
// Step counter, program ROM and branch logic; emits one control word a cycle.
// ----------------------------------------------------------------------------
module rc4v_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rc4v_pkg::cond_t cond,
    output rc4v_pkg::cw_t        cw
);
    import rc4v_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign cw = rom_word(step_reg);

    always_comb
    begin
        step_next = step_reg;
        unique case (cw.br)
            BR_NEXT: step_next = step_reg + 1'b1;
            BR_GOTO: step_next = cw.target;
            BR_IDLE:
            begin
                if (cond.pending)
                    step_next = cw.target;
                else if (cond.accept)
                    step_next = ST_B1;
            end
            BR_FILL:
            begin
                if (cond.n_last)
                    step_next = step_reg + 1'b1;
            end
            BR_KEY:  step_next = cond.i_last ? step_reg + 1'b1 : cw.target;
            BR_EMIT:
            begin
                if (cond.out_free)
                    step_next = cond.accept ? ST_B1 : cw.target;
            end
            default: step_next = ST_IDLE;
        endcase
        // new key: drop any schedule in progress and start over
        if (cond.restart)
            step_next = ST_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= ST_IDLE;
        else
            step_reg <= step_next;
    end

endmodule
`default_nettype wire

/* hdl/rc4_variant_keystream_cipher_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_variant_keystream_cipher_top - RC4-style byte stream cipher
// Encrypts/decrypts bytes with a keystream; schedule adds one key bit a step.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (data_in, last_byte) and output channel (data_out,
//   last_out) use valid/stall; a request moves when valid is high and stall
//   is low. key_wr loads cipher_key and forces a fresh key schedule; write
//   it only while no byte is in flight. A write during a schedule restarts it.
//   Before the first byte after reset, after a key write and after a byte
//   with last_byte set, the block runs the key schedule: it loads the
//   identity permutation, then runs one swap step for each of the 256
//   entries (read S[i], read S[j], write both back), with in_stall high.
//   A taken byte goes through steps B1, B2 and B3 and is emitted in B3,
//   where the next byte may be taken. Each byte needs three reads on the
//   single read port of the permutation memory: S[i], S[j], then the
//   keystream read. A byte that arrives while the block is idle is taken
//   at the next edge. If the receiver stalls, the finished byte waits in
//   the output register and the next byte stays in B3 until that byte leaves.
//   Reset clears i, j and the key, and marks the schedule as needed.
// ----------------------------------------------------------------------------
module rc4_variant_keystream_cipher_top #(
    parameter int KEY_BITS = rc4v_pkg::KEY_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        key_wr,
    input  wire logic [KEY_BITS-1:0]         cipher_key,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [rc4v_pkg::BYTE_W-1:0] data_in,
    input  wire logic                        last_byte,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [rc4v_pkg::BYTE_W-1:0]      data_out,
    output logic                             last_out
);
    import rc4v_pkg::*;

    localparam int KPOS_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int ADDR_W = $clog2(PERM_DEPTH);

    cw_t   cw;
    cond_t cond;

    logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    logic [KEY_BITS-1:0] key_reg;
    logic [ADDR_W-1:0]   i_reg, i_next;
    logic [BYTE_W-1:0]   j_reg;
    logic [ADDR_W-1:0]   n_reg;
    logic [KPOS_W-1:0]   kpos_reg, kpos_next;
    logic [BYTE_W-1:0]   si_reg, k_reg, din_reg;
    logic                last_reg;
    logic                pend_reg, pend_next;
    logic                out_valid_reg;
    logic [BYTE_W-1:0]   data_out_reg;
    logic                last_out_reg;

    logic              acc_ok, accept, out_free, out_load, kbit, rd_en;
    logic [BYTE_W-1:0] j_sum, ks, wdata;
    logic [ADDR_W-1:0] raddr, waddr;

    rc4v_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .cw    (cw)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign acc_ok   = cw.acc_ok && !pend_reg && !key_wr &&
                      (!cw.emit || (out_free && !last_reg));
    assign in_stall = !acc_ok;
    assign accept   = in_valid && acc_ok;
    assign out_load = cw.emit && out_free;

    assign cond.pending  = pend_reg;
    assign cond.accept   = accept;
    assign cond.n_last   = (n_reg == ADDR_W'(PERM_DEPTH - 1));
    assign cond.i_last   = (i_reg == ADDR_W'(PERM_DEPTH - 1));
    assign cond.out_free = out_free;
    assign cond.restart  = key_wr;

    assign kbit  = cw.use_kbit & key_reg[kpos_reg];
    assign j_sum = j_reg + rdata_reg + BYTE_W'(kbit);
    assign rd_en = cw.rd_en || (cw.rd_on_acc && accept);
    // post-swap S[i] is covered by the memory bypass; only k == j needs a fix
    assign ks    = (k_reg == j_reg) ? si_reg : rdata_reg;

    always_comb
    begin
        unique case (cw.rd_src)
            RA_I:    raddr = i_reg;
            RA_I1:   raddr = i_reg + 1'b1;
            RA_JSUM: raddr = j_sum;
            RA_K:    raddr = si_reg + rdata_reg;
            default: raddr = i_reg;
        endcase
        unique case (cw.wa_src)
            WA_N:    waddr = n_reg;
            WA_I:    waddr = i_reg;
            WA_J:    waddr = j_reg;
            default: waddr = n_reg;
        endcase
        unique case (cw.wd_src)
            WD_N:    wdata = n_reg;
            WD_RD:   wdata = rdata_reg;
            WD_SI:   wdata = si_reg;
            default: wdata = n_reg;
        endcase
    end

    always_comb
    begin
        i_next    = i_reg;
        kpos_next = kpos_reg;
        unique case (cw.i_op)
            I_KEEP: i_next = i_reg;
            I_CLR:
            begin
                i_next    = '0;
                kpos_next = '0;
            end
            I_INC:
            begin
                i_next    = i_reg + 1'b1;
                kpos_next = (kpos_reg == KPOS_W'(KEY_BITS - 1)) ? '0 : kpos_reg + 1'b1;
            end
            I_INC_ACC:
            begin
                if (accept)
                    i_next = i_reg + 1'b1;
            end
            default: i_next = i_reg;
        endcase
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (key_wr)
            pend_next = 1'b1;
        else if (cw.pend_clr)
            pend_next = 1'b0;
        else if (out_load && last_reg)
            pend_next = 1'b1;
    end

    // permutation memory: one write, one registered read, write-first bypass
    always_ff @(posedge clk)
    begin
        if (cw.we)
            perm_mem[waddr] <= wdata;
        if (rd_en)
        begin
            if (cw.we && (waddr == raddr))
                rdata_reg <= wdata;
            else
                rdata_reg <= perm_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            kpos_reg      <= '0;
            pend_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (key_wr)
                key_reg <= cipher_key;
            i_reg    <= i_next;
            kpos_reg <= kpos_next;
            if (cw.j_clr)
                j_reg <= '0;
            else if (cw.j_load)
                j_reg <= j_sum;
            // a restarted fill must begin again at entry 0
            if (key_wr)
                n_reg <= '0;
            else if (cw.n_inc)
                n_reg <= n_reg + 1'b1;
            pend_reg <= pend_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cw.si_load)
            si_reg <= rdata_reg;
        if (cw.k_load)
            k_reg <= si_reg + rdata_reg;
        if (accept)
        begin
            din_reg  <= data_in;
            last_reg <= last_byte;
        end
        if (out_load)
        begin
            data_out_reg <= din_reg ^ ks;
            last_out_reg <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign last_out  = last_out_reg;

    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !pend_reg)
        else $error("byte taken while key schedule pending");

    a_sched_wraps_i: assert property (@(posedge clk) disable iff (!rst_n)
        cw.pend_clr |-> (i_reg == '0))
        else $error("schedule ended with i not wrapped");

    a_emit_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.emit && accept) |-> (out_free && !last_reg))
        else $error("overlapped request taken without room or after last byte");

    a_fill_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        cw.n_inc |-> !rd_en)
        else $error("read issued during permutation fill");

endmodule
`default_nettype wire
